// ===== rtl/fra_pkg.sv =====
// Shared constants, codes and beat types of the free range allocator.
package fra_pkg;

  localparam int unsigned MaxRanges = 16;
  localparam int unsigned AddrBits  = 32;
  localparam int unsigned IdxW      = $clog2(MaxRanges);
  localparam int unsigned CntW      = $clog2(MaxRanges + 1);

  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_REMOVE  = 2'd1;
  localparam logic [1:0] CMD_FIND    = 2'd2;
  localparam logic [1:0] CMD_FIND_AT = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]          command;
    logic [AddrBits-1:0] range_address;
    logic [AddrBits-1:0] range_size;
    logic [4:0]          align_log2;
  } in_item_t;

  typedef struct packed {
    logic [AddrBits-1:0] claimed_address;
    logic [1:0]          status;
    logic [4:0]          free_range_count;
  } out_item_t;

  typedef struct packed {
    logic [AddrBits-1:0] start;
    logic [AddrBits-1:0] length;
  } entry_t;

endpackage

// ===== rtl/fra_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module fra_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/free_range_allocator_top.sv =====
// Top level of the free range allocator: command sequencer around the range table RAM.
//
// The block keeps an address-sorted table of free ranges in one RAM and takes one
// command beat at a time. Insert, remove and find-at walk the table from entry 0,
// reading each entry visited and then comparing it; a first-fit find also checks
// the fit of each entry it visits. Any insertion or deletion shifts the entries
// above it one at a time, each moved entry read and then written back through the
// same RAM. A find walks twice: once to choose the range and once to claim the
// span. A finished result waits in an output register while the next command beat
// is already accepted. No clearing pass follows reset.
module free_range_allocator_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fra_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fra_pkg::out_item_t out_data_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_RD      = 4'd1;
  localparam logic [3:0] S_CHK     = 4'd2;
  localparam logic [3:0] S_FIT     = 4'd3;
  localparam logic [3:0] S_INS_DEC = 4'd4;
  localparam logic [3:0] S_REM_DEC = 4'd5;
  localparam logic [3:0] S_OPEN_RD = 4'd6;
  localparam logic [3:0] S_OPEN_WR = 4'd7;
  localparam logic [3:0] S_DROP_RD = 4'd8;
  localparam logic [3:0] S_DROP_WR = 4'd9;
  localparam logic [3:0] S_DONE    = 4'd10;

  localparam int unsigned AW = fra_pkg::AddrBits;
  localparam int unsigned CW = fra_pkg::CntW;
  localparam int unsigned IW = fra_pkg::IdxW;

  logic [3:0]  state_q, state_d;
  logic [1:0]  op_q, op_d;
  logic        find_q, find_d;
  logic [AW-1:0] a_q, a_d, sz_q, sz_d, pad_q, pad_d;
  logic [4:0]  lg_q, lg_d;
  logic [CW-1:0] idx_q, idx_d, sh_q, sh_d, pos_q, pos_d, count_q, count_d;
  fra_pkg::entry_t prev_q, prev_d, cur_q, cur_d, new_q, new_d;
  logic [1:0]  st_q, st_d;
  logic        out_valid_q, out_valid_d;
  fra_pkg::out_item_t out_q, out_d;

  logic            ram_we;
  logic [IW-1:0]   ram_waddr, ram_raddr;
  fra_pkg::entry_t ram_wdata, rd;

  logic [AW-1:0] rd_end, mask, delta, pad_c, need, cur_end, cut;
  logic [CW-1:0] idx_m1, idx_p1, sh_m1, sh_p1;

  fra_ram #(
    .Width($bits(fra_pkg::entry_t)),
    .Depth(fra_pkg::MaxRanges)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(rd)
  );

  assign idx_m1  = idx_q - CW'(1);
  assign idx_p1  = idx_q + CW'(1);
  assign sh_m1   = sh_q - CW'(1);
  assign sh_p1   = sh_q + CW'(1);
  assign rd_end  = rd.start + rd.length;
  assign mask    = (AW'(1) << lg_q) - AW'(1);
  assign delta   = rd.start & mask;
  assign pad_c   = (delta != '0) ? ((AW'(1) << lg_q) - delta) : '0;
  assign need    = sz_q + pad_q;
  assign cur_end = cur_q.start + cur_q.length;
  assign cut     = a_q + sz_q;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    find_d      = find_q;
    a_d         = a_q;
    sz_d        = sz_q;
    lg_d        = lg_q;
    pad_d       = pad_q;
    idx_d       = idx_q;
    sh_d        = sh_q;
    pos_d       = pos_q;
    count_d     = count_q;
    prev_d      = prev_q;
    cur_d       = cur_q;
    new_d       = new_q;
    st_d        = st_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q[IW-1:0];
    ram_wdata   = new_q;
    ram_raddr   = idx_q[IW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = in_data_i.command;
          find_d  = 1'b0;
          a_d     = in_data_i.range_address;
          sz_d    = in_data_i.range_size;
          lg_d    = in_data_i.align_log2;
          idx_d   = '0;
          state_d = S_RD;
        end
      end
      S_RD: begin
        if (idx_q == count_q) begin
          if (op_q == fra_pkg::CMD_INSERT) begin
            state_d = S_INS_DEC;
          end else begin
            st_d    = fra_pkg::ST_MISS;
            state_d = S_DONE;
          end
        end else begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        state_d = S_RD;
        case (op_q)
          fra_pkg::CMD_INSERT: begin
            if (rd.start < a_q) begin
              prev_d = rd;
              idx_d  = idx_p1;
            end else begin
              cur_d   = rd;
              state_d = S_INS_DEC;
            end
          end
          fra_pkg::CMD_REMOVE: begin
            if (rd_end < a_q) begin
              idx_d = idx_p1;
            end else if (a_q < rd.start) begin
              st_d    = fra_pkg::ST_MISS;
              state_d = S_DONE;
            end else begin
              cur_d   = rd;
              state_d = S_REM_DEC;
            end
          end
          fra_pkg::CMD_FIND: begin
            cur_d   = rd;
            pad_d   = pad_c;
            state_d = S_FIT;
          end
          default: begin
            if (rd.start == a_q) begin
              cur_d   = rd;
              pad_d   = pad_c;
              state_d = S_FIT;
            end else begin
              idx_d = idx_p1;
            end
          end
        endcase
      end
      S_FIT: begin
        if (cur_q.length >= need) begin
          a_d     = cur_q.start + pad_q;
          op_d    = fra_pkg::CMD_REMOVE;
          find_d  = 1'b1;
          idx_d   = '0;
          state_d = S_RD;
        end else if (op_q == fra_pkg::CMD_FIND) begin
          idx_d   = idx_p1;
          state_d = S_RD;
        end else begin
          st_d    = fra_pkg::ST_MISS;
          state_d = S_DONE;
        end
      end
      S_INS_DEC: begin
        st_d    = fra_pkg::ST_OK;
        state_d = S_DONE;
        if ((idx_q != '0) && (a_q == prev_q.start + prev_q.length)) begin
          ram_we          = 1'b1;
          ram_waddr       = idx_m1[IW-1:0];
          ram_wdata.start = prev_q.start;
          if ((idx_q != count_q) && (cut == cur_q.start)) begin
            ram_wdata.length = prev_q.length + sz_q + cur_q.length;
            sh_d             = idx_q;
            state_d          = S_DROP_RD;
          end else begin
            ram_wdata.length = prev_q.length + sz_q;
          end
        end else if ((idx_q != count_q) && (cut == cur_q.start)) begin
          ram_we           = 1'b1;
          ram_wdata.start  = a_q;
          ram_wdata.length = cur_q.length + sz_q;
        end else if (count_q == CW'(fra_pkg::MaxRanges)) begin
          st_d = fra_pkg::ST_FULL;
        end else begin
          new_d.start  = a_q;
          new_d.length = sz_q;
          pos_d        = idx_q;
          sh_d         = count_q;
          state_d      = S_OPEN_RD;
        end
      end
      S_REM_DEC: begin
        st_d    = fra_pkg::ST_OK;
        state_d = S_DONE;
        if (a_q > cur_q.start) begin
          if ((cur_end > cut) && (count_q == CW'(fra_pkg::MaxRanges))) begin
            st_d = fra_pkg::ST_FULL;
          end else begin
            ram_we           = 1'b1;
            ram_wdata.start  = cur_q.start;
            ram_wdata.length = a_q - cur_q.start;
            if (cur_end > cut) begin
              new_d.start  = cut;
              new_d.length = cur_end - cut;
              pos_d        = idx_p1;
              sh_d         = count_q;
              state_d      = S_OPEN_RD;
            end
          end
        end else if (cur_end > cut) begin
          ram_we           = 1'b1;
          ram_wdata.start  = cut;
          ram_wdata.length = cur_q.length - sz_q;
        end else begin
          sh_d    = idx_q;
          state_d = S_DROP_RD;
        end
      end
      S_OPEN_RD: begin
        ram_raddr = sh_m1[IW-1:0];
        if (sh_q == pos_q) begin
          ram_we    = 1'b1;
          ram_waddr = pos_q[IW-1:0];
          ram_wdata = new_q;
          count_d   = count_q + CW'(1);
          st_d      = fra_pkg::ST_OK;
          state_d   = S_DONE;
        end else begin
          state_d = S_OPEN_WR;
        end
      end
      S_OPEN_WR: begin
        ram_we    = 1'b1;
        ram_waddr = sh_q[IW-1:0];
        ram_wdata = rd;
        sh_d      = sh_m1;
        state_d   = S_OPEN_RD;
      end
      S_DROP_RD: begin
        ram_raddr = sh_p1[IW-1:0];
        if (sh_p1 >= count_q) begin
          count_d = count_q - CW'(1);
          st_d    = fra_pkg::ST_OK;
          state_d = S_DONE;
        end else begin
          state_d = S_DROP_WR;
        end
      end
      S_DROP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = sh_q[IW-1:0];
        ram_wdata = rd;
        sh_d      = sh_p1;
        state_d   = S_DROP_RD;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d                = 1'b1;
          out_d.claimed_address      = (find_q && (st_q == fra_pkg::ST_OK)) ? a_q : '0;
          out_d.status               = st_q;
          out_d.free_range_count     = 5'(count_q);
          state_d                    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    find_q <= find_d;
    a_q    <= a_d;
    sz_q   <= sz_d;
    lg_q   <= lg_d;
    pad_q  <= pad_d;
    idx_q  <= idx_d;
    sh_q   <= sh_d;
    pos_q  <= pos_d;
    prev_q <= prev_d;
    cur_q  <= cur_d;
    new_q  <= new_d;
    st_q   <= st_d;
    out_q  <= out_d;
  end

endmodule
